>>> sv/q2r_pkg.sv
// Package for the quad-to-rectangle address mapper: widths, register codes, sideband struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q2r_pkg;
  localparam int COORD_BITS = 12;
  localparam int NUM_W      = 2 * COORD_BITS + 1;  // biased dividend magnitude
  localparam int PROD_W     = 2 * COORD_BITS + 2;  // signed delta * t
  localparam int CORNER_W   = 2 * COORD_BITS;
  localparam int IDX_W      = 3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [IDX_W-1:0] {
    REG_TL     = 3'd0,
    REG_BL     = 3'd1,
    REG_BR     = 3'd2,
    REG_TR     = 3'd3,
    REG_CUSTOM = 3'd4,
    REG_CW     = 3'd5,
    REG_CH     = 3'd6
  } reg_idx_t;

  // Per-beat context carried alongside the interpolation lanes.
  typedef struct packed {
    coord_t row;
    coord_t w;
    coord_t h;
    logic   empty;
    logic   outside;
  } side_t;
endpackage
`default_nettype wire

>>> sv/q2r_in_if.sv
// Input beat channel: destination pixel.
// Depends on q2r_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface q2r_in_if;
  import q2r_pkg::*;
  logic   valid;
  logic   ready;
  coord_t dest_col;
  coord_t dest_row;
  modport source (output valid, dest_col, dest_row, input ready);
  modport sink (input valid, dest_col, dest_row, output ready);
endinterface
`default_nettype wire

>>> sv/q2r_out_if.sv
// Result beat channel: source address, flags and sizes.
// Depends on q2r_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface q2r_out_if;
  import q2r_pkg::*;
  logic   valid;
  logic   ready;
  coord_t source_x;
  coord_t source_y;
  logic   dest_outside;
  logic   region_empty;
  coord_t output_width;
  coord_t output_height;
  modport source (output valid, source_x, source_y, dest_outside, region_empty,
                  output_width, output_height, input ready);
  modport sink (input valid, source_x, source_y, dest_outside, region_empty,
                output_width, output_height, output ready);
endinterface
`default_nettype wire

>>> sv/q2r_cfg_if.sv
// Configuration write channel: register index and data.
// Depends on q2r_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface q2r_cfg_if;
  import q2r_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    index;
  logic [CORNER_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/quad_to_rect_bilinear_address_top.sv
// Top level of the quad-to-rectangle address mapper.
// Depends on q2r_pkg, the three channel interfaces and q2r_lerp.
//
// Usage:
//   cfg_if : register writes (index 0..6: four corners, custom-size enable,
//            custom width, custom height). Always ready; unknown indexes are
//            dropped. Write only while no beat is in flight.
//   in_if  : one destination pixel (dest_col, dest_row) per beat.
//   out_if : one result beat per input beat, in order: source_x/source_y,
//            outside and empty flags, output width/height in use.
// Throughput: one beat per cycle, sustained while no result is stalled at the output.
// Pipeline: 30 register stages in two chained interpolators (edge points
//   along the columns, then along the rows), each a multiply stage, a bias
//   stage, 12 restoring-division cells (one quotient bit per cell) and a
//   final add.
// Stall: the whole pipe freezes while a result sits unaccepted at the
//   output register; in_if.ready drops only then. No beat is lost.
// Reset: rst_n (sync, active low) empties the pipe and restores the
//   register defaults (corners 0, custom size off, 720 x 480).
`timescale 1ns / 1ps
`default_nettype none
module quad_to_rect_bilinear_address_top (
  input  logic clk,
  input  logic rst_n,
  q2r_cfg_if.sink   cfg_if,
  q2r_in_if.sink    in_if,
  q2r_out_if.source out_if
);
  import q2r_pkg::*;

  // config registers, corners stored split into x/y
  coord_t [3:0] cx_r;
  coord_t [3:0] cy_r;
  logic         custom_r;
  coord_t       cw_r;
  coord_t       ch_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      custom_r <= 1'b0;
      cw_r     <= coord_t'(720);
      ch_r     <= coord_t'(480);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_TL, REG_BL, REG_BR, REG_TR: begin
          cx_r[cfg_if.index[1:0]] <= cfg_if.data[COORD_BITS-1:0];
          cy_r[cfg_if.index[1:0]] <= cfg_if.data[CORNER_W-1:COORD_BITS];
        end
        REG_CUSTOM: custom_r <= cfg_if.data[0];
        REG_CW:     cw_r     <= cfg_if.data[COORD_BITS-1:0];
        REG_CH:     ch_r     <= cfg_if.data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // corner slots: 0 TL, 1 BL, 2 BR, 3 TR
  coord_t left, top, right, bottom;
  logic signed [COORD_BITS:0] wd, hd;
  coord_t w, h;
  logic   empty, outside;
  side_t  side_in;

  always_comb begin
    left   = (cx_r[0] < cx_r[1]) ? cx_r[0] : cx_r[1];
    top    = (cy_r[0] < cy_r[3]) ? cy_r[0] : cy_r[3];
    right  = (cx_r[3] > cx_r[2]) ? cx_r[3] : cx_r[2];
    bottom = (cy_r[1] > cy_r[2]) ? cy_r[1] : cy_r[2];
    wd     = $signed({1'b0, right}) - $signed({1'b0, left});
    hd     = $signed({1'b0, bottom}) - $signed({1'b0, top});
    if (custom_r) begin
      w     = cw_r;
      h     = ch_r;
      empty = (cw_r == '0) || (ch_r == '0);
    end else begin
      w     = wd[COORD_BITS-1:0];
      h     = hd[COORD_BITS-1:0];
      empty = (wd <= 0) || (hd <= 0);
    end
    outside         = (in_if.dest_col >= w) || (in_if.dest_row >= h);
    side_in.row     = in_if.dest_row;
    side_in.w       = w;
    side_in.h       = h;
    side_in.empty   = empty;
    side_in.outside = outside;
  end

  logic en;
  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  // edge points: lanes topx, topy, botx, boty
  coord_t [3:0] a1, b1, res1;
  side_t        side1;
  logic         vld1;

  assign a1 = {cy_r[1], cx_r[1], cy_r[0], cx_r[0]};
  assign b1 = {cy_r[2], cx_r[2], cy_r[3], cx_r[3]};

  q2r_lerp #(.LANES(4)) u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_if.valid),
    .a      (a1),
    .b      (b1),
    .t      (in_if.dest_col),
    .n      (w),
    .side_i (side_in),
    .vld_r  (vld1),
    .res_r  (res1),
    .side_r (side1)
  );

  // source point: lanes x, y
  coord_t [1:0] a2, b2, res2;
  side_t        side2;

  assign a2 = {res1[1], res1[0]};
  assign b2 = {res1[3], res1[2]};

  q2r_lerp #(.LANES(2)) u_span (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld1),
    .a      (a2),
    .b      (b2),
    .t      (side1.row),
    .n      (side1.h),
    .side_i (side1),
    .vld_r  (out_if.valid),
    .res_r  (res2),
    .side_r (side2)
  );

  // masking of the flagged cases
  logic flag;
  assign flag                 = side2.empty || side2.outside;
  assign out_if.source_x      = flag ? '0 : res2[0];
  assign out_if.source_y      = flag ? '0 : res2[1];
  assign out_if.dest_outside  = flag;
  assign out_if.region_empty  = side2.empty;
  assign out_if.output_width  = side2.empty ? '0 : side2.w;
  assign out_if.output_height = side2.empty ? '0 : side2.h;
endmodule
`default_nettype wire

>>> sv/q2r_div_cell.sv
// One restoring-division cell: tries n << SHIFT, sets one quotient bit, registers.
// Depends on q2r_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2r_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  q2r_pkg::coord_t      n,
  input  logic [q2r_pkg::NUM_W-1:0] rem_i,
  input  q2r_pkg::coord_t      q_i,
  output logic [q2r_pkg::NUM_W-1:0] rem_r,
  output q2r_pkg::coord_t      q_r
);
  import q2r_pkg::*;

  logic [NUM_W-1:0] dsub;
  logic             ge;
  logic [NUM_W-1:0] rem_nxt;
  coord_t           q_nxt;

  always_comb begin
    dsub    = NUM_W'(n) << SHIFT;
    ge      = rem_i >= dsub;
    rem_nxt = ge ? rem_i - dsub : rem_i;
    q_nxt   = ge ? (q_i | (coord_t'(1) << SHIFT)) : q_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end
endmodule
`default_nettype wire

>>> sv/q2r_lerp.sv
// Floor interpolation a + floor((b-a)*t/n) over LANES lanes sharing t and n:
// multiply stage, bias stage, a row of COORD_BITS division cells, final add.
// Depends on q2r_pkg and q2r_div_cell.
`timescale 1ns / 1ps
`default_nettype none
module q2r_lerp #(
  parameter int LANES = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  q2r_pkg::coord_t [LANES-1:0] a,
  input  q2r_pkg::coord_t [LANES-1:0] b,
  input  q2r_pkg::coord_t             t,
  input  q2r_pkg::coord_t             n,
  input  q2r_pkg::side_t              side_i,
  output logic                        vld_r,
  output q2r_pkg::coord_t [LANES-1:0] res_r,
  output q2r_pkg::side_t              side_r
);
  import q2r_pkg::*;

  localparam int STEPS = COORD_BITS;

  // multiply stage
  logic signed [PROD_W-1:0] prod_r [LANES];
  coord_t [LANES-1:0]       a_m_r;
  coord_t                   n_m_r;
  side_t                    side_m_r;
  logic                     vld_m_r;

  // division row, index 0 is the bias stage
  logic [NUM_W-1:0]   rem_d [STEPS+1][LANES];
  coord_t             q_d   [STEPS+1][LANES];
  coord_t [LANES-1:0] a_d   [STEPS+1];
  logic   [LANES-1:0] neg_d [STEPS+1];
  coord_t             n_d   [STEPS];
  side_t              side_d[STEPS+1];
  logic               vld_d [STEPS+1];

  logic signed [PROD_W-1:0] prod_nxt [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod_nxt[l] = PROD_W'($signed({1'b0, b[l]}) - $signed({1'b0, a[l]}))
                  * PROD_W'($signed({1'b0, t}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        prod_r[l] <= prod_nxt[l];
      end
      a_m_r    <= a;
      n_m_r    <= n;
      side_m_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m_r <= 1'b0;
    end else if (en) begin
      vld_m_r <= vld_i;
    end
  end

  // bias: floor(p/n) = -((-p + n - 1) / n) for negative p
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        neg_d[0][l] <= prod_r[l][PROD_W-1];
        q_d[0][l]   <= '0;
        if (prod_r[l][PROD_W-1]) begin
          rem_d[0][l] <= NUM_W'(-prod_r[l] + PROD_W'(n_m_r) - PROD_W'(1));
        end else begin
          rem_d[0][l] <= NUM_W'(prod_r[l]);
        end
      end
      a_d[0]    <= a_m_r;
      n_d[0]    <= n_m_r;
      side_d[0] <= side_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d[0] <= 1'b0;
    end else if (en) begin
      vld_d[0] <= vld_m_r;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      q2r_div_cell #(.SHIFT(STEPS - 1 - k)) u_cell (
        .clk   (clk),
        .en    (en),
        .n     (n_d[k]),
        .rem_i (rem_d[k][l]),
        .q_i   (q_d[k][l]),
        .rem_r (rem_d[k+1][l]),
        .q_r   (q_d[k+1][l])
      );
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_d[k+1]    <= a_d[k];
        neg_d[k+1]  <= neg_d[k];
        side_d[k+1] <= side_d[k];
      end
    end

    // divisor is not needed past the last cell
    if (k < STEPS - 1) begin : g_n
      always_ff @(posedge clk) begin
        if (en) begin
          n_d[k+1] <= n_d[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_d[k+1] <= 1'b0;
      end else if (en) begin
        vld_d[k+1] <= vld_d[k];
      end
    end
  end

  // final add with sign restore
  coord_t [LANES-1:0] res_nxt;
  logic [COORD_BITS:0] qs;

  always_comb begin
    res_nxt = '0;
    qs      = '0;
    for (int l = 0; l < LANES; l++) begin
      qs = neg_d[STEPS][l] ? -{1'b0, q_d[STEPS][l]} : {1'b0, q_d[STEPS][l]};
      res_nxt[l] = coord_t'({1'b0, a_d[STEPS][l]} + qs);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      side_r <= side_d[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_d[STEPS];
    end
  end
endmodule
`default_nettype wire
